@@ rtl/gwm_pkg.sv @@
// Shared types and constants for the glob wildcard matcher.
// No dependencies; imported by every module of the matcher.
package gwm_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_PAT_CHR  = 2'd0;
  localparam logic [1:0] FUNC_PAT_END  = 2'd1;
  localparam logic [1:0] FUNC_SUBJ_CHR = 2'd2;
  localparam logic [1:0] FUNC_SUBJ_END = 2'd3;

  // Wildcard character codes
  localparam int unsigned SYM_STAR = 42;
  localparam int unsigned SYM_ANY  = 63;

  // Item kinds as they travel down the cell chain
  typedef enum logic [2:0] {
    K_PAT_NEW,     // clear the pattern, then store the character
    K_PAT_WR,      // append the character
    K_REARM,       // set position zero and close over stars
    K_SUBJ_CHR,    // advance the active positions by one character
    K_END_ARMED,   // report the end position, then rearm
    K_END_OPEN     // report no match, touch nothing
  } gwm_kind_t;

  // Control part of an item in flight between cells
  typedef struct packed {
    logic      vld;
    gwm_kind_t kind;
    logic      carry;  // next-state bit handed to the following position
    logic      done;   // character placed, or end position found
    logic      hit;    // active bit of the end position
    logic      ovf;    // overflow flag seen at entry
  } gwm_tok_t;

endpackage

@@ rtl/gwm_head.sv @@
// Entry stage: classifies each accepted item and tracks pattern length,
// closed and overflow status. Depends on gwm_pkg.
module gwm_head #(
  parameter int PATTERN_MAX = 64,
  parameter int CW          = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [1:0]          func,
  input  logic [15:0]         char_code,
  output gwm_pkg::gwm_tok_t   tok,
  output logic [CW-1:0]       chr
);
  import gwm_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);

  logic [LW-1:0] len_r, len_nxt;
  logic          closed_r, closed_nxt;
  logic          ovf_r, ovf_nxt;

  assign chr = char_code[CW-1:0];

  always_comb begin
    len_nxt    = len_r;
    closed_nxt = closed_r;
    ovf_nxt    = ovf_r;
    tok        = '0;
    tok.kind   = K_END_OPEN;
    tok.ovf    = ovf_r;
    unique case (func)
      FUNC_PAT_CHR: begin
        if (closed_r) begin
          tok.vld    = acc;
          tok.kind   = K_PAT_NEW;
          closed_nxt = 1'b0;
          ovf_nxt    = 1'b0;
          len_nxt    = LW'(1);
        end else if (len_r < LW'(PATTERN_MAX)) begin
          tok.vld  = acc;
          tok.kind = K_PAT_WR;
          len_nxt  = len_r + LW'(1);
        end else begin
          ovf_nxt = 1'b1;  // drop the character
        end
      end
      FUNC_PAT_END: begin
        tok.vld    = acc;
        tok.kind   = K_REARM;
        tok.carry  = 1'b1;
        closed_nxt = 1'b1;
      end
      FUNC_SUBJ_CHR: begin
        tok.vld  = acc & closed_r;
        tok.kind = K_SUBJ_CHR;
      end
      FUNC_SUBJ_END: begin
        tok.vld   = acc;
        tok.kind  = closed_r ? K_END_ARMED : K_END_OPEN;
        tok.carry = closed_r;
      end
      default: begin
        tok.vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      closed_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else if (acc) begin
      len_r    <= len_nxt;
      closed_r <= closed_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

@@ rtl/gwm_cell.sv @@
// One pattern position: holds its character and active bit and passes
// the item on to the next position through a register held by the advance enable. Depends on gwm_pkg.
module gwm_cell #(
  parameter int CW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  gwm_pkg::gwm_tok_t tok_in,
  input  logic [CW-1:0]     chr_in,
  output gwm_pkg::gwm_tok_t tok_r,
  output logic [CW-1:0]     chr_r
);
  import gwm_pkg::*;

  logic [CW-1:0] pat_r, pat_nxt;
  logic          used_r, used_nxt;
  logic          act_r, act_nxt;
  gwm_tok_t      tok_nxt;
  logic          used_eff, is_star, is_step, nxt_bit;

  assign used_eff = (tok_in.kind == K_PAT_NEW) ? 1'b0 : used_r;
  assign is_star  = (pat_r == CW'(SYM_STAR));
  assign is_step  = (pat_r == CW'(SYM_ANY)) || (pat_r == chr_in);

  always_comb begin
    pat_nxt  = pat_r;
    used_nxt = used_r;
    act_nxt  = act_r;
    tok_nxt  = tok_in;
    nxt_bit  = 1'b0;
    unique case (tok_in.kind)
      K_PAT_NEW, K_PAT_WR: begin
        used_nxt = used_eff;
        if (tok_in.kind == K_PAT_NEW) act_nxt = 1'b0;
        if (!used_eff && !tok_in.done) begin
          pat_nxt      = chr_in;
          used_nxt     = 1'b1;
          tok_nxt.done = 1'b1;
        end
      end
      K_REARM, K_END_ARMED: begin
        // report first unused position on a subject end, then rearm
        if (tok_in.kind == K_END_ARMED && !used_r && !tok_in.done) begin
          tok_nxt.hit  = act_r;
          tok_nxt.done = 1'b1;
        end
        nxt_bit       = tok_in.carry;
        act_nxt       = nxt_bit;
        tok_nxt.carry = used_r & is_star & nxt_bit;
      end
      K_SUBJ_CHR: begin
        nxt_bit       = tok_in.carry | (act_r & used_r & is_star);
        act_nxt       = nxt_bit;
        tok_nxt.carry = used_r & ((act_r & !is_star & is_step) | (nxt_bit & is_star));
      end
      K_END_OPEN: begin
        tok_nxt = tok_in;
      end
      default: begin
        tok_nxt = tok_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      act_r  <= 1'b0;
      tok_r  <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      if (tok_in.vld) begin
        used_r <= used_nxt;
        act_r  <= act_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chr_r <= chr_in;
      if (tok_in.vld) pat_r <= pat_nxt;
    end
  end

endmodule

@@ rtl/gwm_tail.sv @@
// Last position of the chain and the result register with its handshake.
// Drives the chain advance enable. Depends on gwm_pkg.
module gwm_tail (
  input  logic              clk,
  input  logic              rst_n,
  input  gwm_pkg::gwm_tok_t tok_in,
  input  logic              out_ready,
  output logic              adv,
  output logic              out_valid,
  output logic              out_matched,
  output logic              out_pattern_overflow
);
  import gwm_pkg::*;

  logic act_r;
  logic is_res;
  logic out_valid_r;
  logic matched_r, ovf_r;
  logic hit;

  assign is_res = tok_in.vld &&
                  (tok_in.kind == K_END_ARMED || tok_in.kind == K_END_OPEN);
  // hold the chain only when a result has nowhere to go
  assign adv    = !(is_res && out_valid_r && !out_ready);
  assign hit    = tok_in.done ? tok_in.hit : act_r;

  assign out_valid            = out_valid_r;
  assign out_matched          = matched_r;
  assign out_pattern_overflow = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv && is_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (adv && tok_in.vld) begin
        unique case (tok_in.kind)
          K_PAT_NEW:                         act_r <= 1'b0;
          K_REARM, K_SUBJ_CHR, K_END_ARMED:  act_r <= tok_in.carry;
          K_PAT_WR, K_END_OPEN:              act_r <= act_r;
          default:                           act_r <= act_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_res) begin
      matched_r <= (tok_in.kind == K_END_ARMED) && hit && !tok_in.ovf;
      ovf_r     <= tok_in.ovf;
    end
  end

endmodule

@@ rtl/glob_wildcard_matcher.sv @@
// Top level of the glob wildcard matcher: entry stage, chain of position
// cells and tail stage. Depends on gwm_pkg, gwm_head, gwm_cell, gwm_tail.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid, in_ready, in_func, in_char_code  | in
//   result  | out_valid, out_ready, out_matched,         | out
//           | out_pattern_overflow                       |
//
// One item enters per cycle while the chain is not stalled. Each item walks
// the chain one position per cycle, through the register of each cell,
// and the tail registers the result of a subject end.
// Reset clears lengths, flags, active bits and all in-flight items; the
// pattern characters themselves are not cleared.
// The whole chain and in_ready stall only when a subject end reaches the
// tail while the result register is full and out_ready is low.
//
// Each cell owns one pattern position. A subject character is compared in
// cell j and the resulting next-state bit for position j+1 is handed over
// with the item, together with star closure, so no signal spans more than
// two neighboring cells. The end position is found by the first unused
// cell the subject end item meets; position PATTERN_MAX lives in the tail.
module glob_wildcard_matcher #(
  parameter int PATTERN_MAX = 64,
  parameter int CHAR_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_matched,
  output logic        out_pattern_overflow
);
  import gwm_pkg::*;

  // only the low CHAR_BITS of the 16-bit code take part
  localparam int CW = (CHAR_BITS < 16) ? CHAR_BITS : 16;

  gwm_tok_t      tok [PATTERN_MAX+1];
  logic [CW-1:0] chr [PATTERN_MAX+1];
  logic          adv;

  assign in_ready = adv;

  gwm_head #(
    .PATTERN_MAX (PATTERN_MAX),
    .CW          (CW)
  ) u_head (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_valid & adv),
    .func      (in_func),
    .char_code (in_char_code),
    .tok       (tok[0]),
    .chr       (chr[0])
  );

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    gwm_cell #(
      .CW (CW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .tok_in (tok[j]),
      .chr_in (chr[j]),
      .tok_r  (tok[j+1]),
      .chr_r  (chr[j+1])
    );
  end

  gwm_tail u_tail (
    .clk                  (clk),
    .rst_n                (rst_n),
    .tok_in               (tok[PATTERN_MAX]),
    .out_ready            (out_ready),
    .adv                  (adv),
    .out_valid            (out_valid),
    .out_matched          (out_matched),
    .out_pattern_overflow (out_pattern_overflow)
  );

endmodule
